// ===== src/xmpp_stream_to_extractor_core_defines.svh =====
// Assertion macros shared by the checker of the stream extractor.
// Stands alone: no other file is needed.
`ifndef XMPP_STREAM_TO_EXTRACTOR_CORE_DEFINES_SVH
`define XMPP_STREAM_TO_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define XSTE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define XSTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/xste_pkg.sv =====
// Types and constants of the XMPP stream "to" extractor.
// Used by the core and the checker; depends on nothing.
package xste_pkg;

   localparam int MAX_HEADER = 4096;
   localparam int HOST_LIMIT = 256;
   localparam int STORE_SIZE = HOST_LIMIT - 1;
   localparam int STORE_AW   = $clog2(STORE_SIZE);
   localparam int VLEN_W     = $clog2(HOST_LIMIT + 1);
   localparam int COUNT_W    = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      STATUS_PENDING    = 3'd0,
      STATUS_FOUND      = 3'd1,
      STATUS_INCOMPLETE = 3'd2,
      STATUS_NO_TO      = 3'd3,
      STATUS_INVALID    = 3'd4
   } status_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_READ = 1'b1
   } operation_type;

   typedef enum logic [3:0] {
      PH_PROLOG, PH_QMARK, PH_MATCH, PH_A_WS, PH_A_NAME, PH_A_POST_NAME,
      PH_A_POST_EQ, PH_A_VALUE, PH_WAIT_FOUND, PH_WAIT_NO_TO, PH_WAIT_INVALID,
      PH_DONE_FOUND, PH_DONE_INCOMPLETE, PH_DONE_NO_TO, PH_DONE_INVALID
   } phase_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       end_of_buffer;
      logic [7:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] host_length;
      logic [7:0] host_byte;
   } rsp_word_type;

   typedef struct packed {
      phase_type          phase;
      logic               in_declaration;
      logic [3:0]         tag_match_pos;
      logic [COUNT_W-1:0] byte_count;
      logic [1:0]         name_count;
      logic               name_is_to;
      logic               quote_is_double;
      logic [VLEN_W-1:0]  val_count;
   } parse_state_type;

endpackage

// ===== src/xste_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; holds the extracted host bytes in the extractor.
module xste_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/xmpp_stream_to_extractor_core.sv =====
// A word accepted into the input register has its result written to the result register
// and presented on rsp once the result stage is free, that is when rsp is not stalled.
// Throughput: one word per cycle while rsp is not stalled; the parser updates once per data word in the
// stage after the input register, and the host store has one read and one write port.
// Reset clears the parser, the verdict and both pipeline stages at once; the host
// store is not cleared and holds only what a "to" value wrote into it.
module xmpp_stream_to_extractor_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  xste_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output xste_pkg::rsp_word_type rsp_word
);

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_boundary(input logic [7:0] c);
      return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == ">");
   endfunction

   function automatic logic [7:0] tag_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:  ch = "<";
         4'd1:  ch = "s";
         4'd2:  ch = "t";
         4'd3:  ch = "r";
         4'd4:  ch = "e";
         4'd5:  ch = "a";
         4'd6:  ch = "m";
         4'd7:  ch = ":";
         4'd8:  ch = "s";
         4'd9:  ch = "t";
         4'd10: ch = "r";
         4'd11: ch = "e";
         4'd12: ch = "a";
         4'd13: ch = "m";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic name_matches(input xste_pkg::parse_state_type s);
      return (s.name_count == 2'd2) && s.name_is_to;
   endfunction

   function automatic logic [7:0] quote_char(input xste_pkg::parse_state_type s);
      return s.quote_is_double ? 8'h22 : 8'h27;
   endfunction

   // One byte inside the opening tag, after the tag name.
   function automatic xste_pkg::parse_state_type content_step(
      input xste_pkg::parse_state_type s, input logic [7:0] c);
      xste_pkg::parse_state_type r;
      r = s;
      if (c == ">") begin
         unique case (s.phase)
            xste_pkg::PH_A_VALUE:      r.phase = xste_pkg::PH_DONE_INCOMPLETE;
            xste_pkg::PH_WAIT_FOUND:   r.phase = xste_pkg::PH_DONE_FOUND;
            xste_pkg::PH_WAIT_INVALID: r.phase = xste_pkg::PH_DONE_INVALID;
            default:                   r.phase = xste_pkg::PH_DONE_NO_TO;
         endcase
      end else begin
         unique case (s.phase)
            xste_pkg::PH_A_WS, xste_pkg::PH_A_POST_NAME: begin
               if (!is_ws(c)) begin
                  if (c == "=") begin
                     if (s.phase == xste_pkg::PH_A_WS) begin
                        r.name_count = 2'd0;
                        r.name_is_to = 1'b0;
                     end
                     r.phase = xste_pkg::PH_A_POST_EQ;
                  end else begin
                     r.name_count = 2'd1;
                     r.name_is_to = (c == "t");
                     r.phase = xste_pkg::PH_A_NAME;
                  end
               end
            end
            xste_pkg::PH_A_NAME: begin
               if (c == "=") begin
                  r.phase = xste_pkg::PH_A_POST_EQ;
               end else if (is_ws(c)) begin
                  r.phase = xste_pkg::PH_A_POST_NAME;
               end else begin
                  if (s.name_count == 2'd1) begin
                     r.name_is_to = s.name_is_to && (c == "o");
                  end
                  if (s.name_count != 2'd3) begin
                     r.name_count = s.name_count + 2'd1;
                  end
               end
            end
            xste_pkg::PH_A_POST_EQ: begin
               if (!is_ws(c)) begin
                  if ((c == 8'h22) || (c == 8'h27)) begin
                     r.quote_is_double = (c == 8'h22);
                     r.val_count = '0;
                     r.phase = xste_pkg::PH_A_VALUE;
                  end else begin
                     r.phase = xste_pkg::PH_WAIT_INVALID;
                  end
               end
            end
            xste_pkg::PH_A_VALUE: begin
               if (c == quote_char(s)) begin
                  if (!name_matches(s)) begin
                     r.phase = xste_pkg::PH_A_WS;
                  end else if (s.val_count == '0) begin
                     r.phase = xste_pkg::PH_WAIT_NO_TO;
                  end else if (s.val_count >= xste_pkg::VLEN_W'(xste_pkg::HOST_LIMIT)) begin
                     r.phase = xste_pkg::PH_WAIT_INVALID;
                  end else begin
                     r.phase = xste_pkg::PH_WAIT_FOUND;
                  end
               end else if (s.val_count < xste_pkg::VLEN_W'(xste_pkg::HOST_LIMIT)) begin
                  r.val_count = s.val_count + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   function automatic xste_pkg::parse_state_type prolog_step(
      input xste_pkg::parse_state_type s, input logic [7:0] c);
      xste_pkg::parse_state_type r;
      r = s;
      if (c == "<") begin
         r.phase = xste_pkg::PH_MATCH;
         r.tag_match_pos = 4'd1;
      end else if (s.in_declaration && (c == "?")) begin
         r.phase = xste_pkg::PH_QMARK;
      end else begin
         r.phase = xste_pkg::PH_PROLOG;
      end
      return r;
   endfunction

   function automatic xste_pkg::parse_state_type enter_tag(
      input xste_pkg::parse_state_type s, input logic [7:0] c);
      xste_pkg::parse_state_type r;
      r = s;
      r.phase = xste_pkg::PH_A_WS;
      r.name_count = 2'd0;
      r.name_is_to = 1'b0;
      return content_step(r, c);
   endfunction

   function automatic xste_pkg::parse_state_type parse_step(
      input xste_pkg::parse_state_type s, input logic [7:0] c);
      xste_pkg::parse_state_type r;
      r = s;
      if (s.byte_count != xste_pkg::COUNT_MAX) begin
         r.byte_count = s.byte_count + 1'b1;
      end
      unique case (s.phase)
         xste_pkg::PH_PROLOG: r = prolog_step(r, c);
         xste_pkg::PH_QMARK: begin
            if (c == ">") begin
               r.in_declaration = 1'b0;
               r.phase = xste_pkg::PH_PROLOG;
            end else begin
               r = prolog_step(r, c);
            end
         end
         xste_pkg::PH_MATCH: begin
            priority if ((s.tag_match_pos == 4'd1) && (c == "?")) begin
               r.in_declaration = 1'b1;
               r.phase = xste_pkg::PH_PROLOG;
            end else if (s.in_declaration) begin
               r = prolog_step(r, c);
            end else if (s.tag_match_pos == 4'd7) begin
               if (c == ":") begin
                  r.tag_match_pos = 4'd8;
               end else if (is_boundary(c)) begin
                  r = enter_tag(r, c);
               end else begin
                  r.phase = xste_pkg::PH_DONE_INVALID;
               end
            end else if (s.tag_match_pos >= 4'd14) begin
               if (is_boundary(c)) begin
                  r = enter_tag(r, c);
               end else begin
                  r.phase = xste_pkg::PH_DONE_INVALID;
               end
            end else if (c == tag_char(s.tag_match_pos)) begin
               r.tag_match_pos = s.tag_match_pos + 4'd1;
            end else begin
               r.phase = xste_pkg::PH_DONE_INVALID;
            end
         end
         xste_pkg::PH_DONE_FOUND, xste_pkg::PH_DONE_INCOMPLETE,
         xste_pkg::PH_DONE_NO_TO, xste_pkg::PH_DONE_INVALID: begin
         end
         default: r = content_step(r, c);
      endcase
      return r;
   endfunction

   localparam xste_pkg::parse_state_type PARSE_CLEAR = '{
      phase:           xste_pkg::PH_PROLOG,
      in_declaration:  1'b0,
      tag_match_pos:   4'd0,
      byte_count:      '0,
      name_count:      2'd0,
      name_is_to:      1'b0,
      quote_is_double: 1'b0,
      val_count:       '0
   };

   // Pipeline control.
   logic                  s1_valid_ff, s1_valid_in;
   xste_pkg::req_word_type s1_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_free, s1_move, req_accept;

   // Parser and verdict.
   xste_pkg::parse_state_type parse_ff, parse_in, parse_next;
   logic [2:0]            verdict_ff, verdict_in;
   logic [7:0]            verdict_len_ff, verdict_len_in;

   // Result register.
   logic [2:0]            status_ff, status_in;
   logic [7:0]            length_ff, length_in;
   logic                  byte_sel_ff, byte_sel_in;

   // Host store ports.
   logic                  wr_en, rd_en;
   logic [7:0]            rd_data;
   logic [2:0]            last_status;
   logic [7:0]            last_length;
   logic                  is_data, idx_in_store;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign is_data      = (s1_word_ff.operation == xste_pkg::OP_DATA);
   assign idx_in_store = s1_word_ff.read_index < 8'(xste_pkg::STORE_SIZE);

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      parse_next = parse_step(parse_ff, s1_word_ff.data_byte);
      // An oversized buffer is invalid whatever the parser saw.
      last_length = 8'd0;
      if (parse_next.byte_count > xste_pkg::COUNT_W'(xste_pkg::MAX_HEADER)) begin
         last_status = xste_pkg::STATUS_INVALID;
      end else begin
         unique case (parse_next.phase)
            xste_pkg::PH_DONE_FOUND: begin
               last_status = xste_pkg::STATUS_FOUND;
               last_length = parse_next.val_count[7:0];
            end
            xste_pkg::PH_DONE_NO_TO:   last_status = xste_pkg::STATUS_NO_TO;
            xste_pkg::PH_DONE_INVALID: last_status = xste_pkg::STATUS_INVALID;
            default:                   last_status = xste_pkg::STATUS_INCOMPLETE;
         endcase
      end
   end

   always_comb begin
      parse_in       = parse_ff;
      verdict_in     = verdict_ff;
      verdict_len_in = verdict_len_ff;
      status_in      = status_ff;
      length_in      = length_ff;
      byte_sel_in    = byte_sel_ff;
      if (s1_move) begin
         if (!is_data) begin
            status_in   = verdict_ff;
            length_in   = verdict_len_ff;
            byte_sel_in = idx_in_store;
         end else if (s1_word_ff.end_of_buffer) begin
            parse_in       = PARSE_CLEAR;
            verdict_in     = last_status;
            verdict_len_in = last_length;
            status_in      = last_status;
            length_in      = last_length;
            byte_sel_in    = 1'b0;
         end else begin
            parse_in    = parse_next;
            status_in   = xste_pkg::STATUS_PENDING;
            length_in   = 8'd0;
            byte_sel_in = 1'b0;
         end
      end
   end

   // A value byte of the "to" attribute goes into the store.
   always_comb begin
      wr_en = s1_move && is_data && (parse_ff.phase == xste_pkg::PH_A_VALUE)
              && (s1_word_ff.data_byte != ">")
              && (s1_word_ff.data_byte != quote_char(parse_ff))
              && name_matches(parse_ff)
              && (parse_ff.val_count < xste_pkg::VLEN_W'(xste_pkg::STORE_SIZE));
      rd_en = s1_move && !is_data && idx_in_store;
   end

   xste_ram #(
      .WIDTH (8),
      .DEPTH (xste_pkg::STORE_SIZE)
   ) u_host_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (parse_ff.val_count[xste_pkg::STORE_AW-1:0]),
      .wr_data (s1_word_ff.data_byte),
      .rd_en   (rd_en),
      .rd_addr (s1_word_ff.read_index[xste_pkg::STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         parse_ff       <= PARSE_CLEAR;
         verdict_ff     <= xste_pkg::STATUS_PENDING;
         verdict_len_ff <= 8'd0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         parse_ff       <= parse_in;
         verdict_ff     <= verdict_in;
         verdict_len_ff <= verdict_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
      status_ff   <= status_in;
      length_ff   <= length_in;
      byte_sel_ff <= byte_sel_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_word.status      = status_ff;
   assign rsp_word.host_length = length_ff;
   assign rsp_word.host_byte   = byte_sel_ff ? rd_data : 8'd0;

endmodule

// ===== src/xste_checker.sv =====
// Port-level checks of the XMPP stream extractor, bound to the core.
// Depends on xste_pkg and the assertion macros header.
`include "xmpp_stream_to_extractor_core_defines.svh"

module xste_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input xste_pkg::rsp_word_type rsp_word
);

   logic rsp_blocked;
   logic req_taken;

   assign rsp_blocked = rsp_valid && rsp_stall;
   assign req_taken   = req_valid && !req_stall;

   // A word held back on the result side keeps its contents.
   `XSTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked, rsp_valid && $stable(rsp_word), "stalled result word changed")

   // The input side only stalls while a finished word waits at the output.
   `XSTE_ASSERT_IMPL(a_stall_only_when_full, clock, reset, !rsp_blocked, !req_stall, "input stalled with output free")

   // A taken word reaches the output if the output is not blocked while it waits in the input register.
   `XSTE_ASSERT_NEXT(a_two_cycle_latency, clock, reset, req_taken ##1 !rsp_blocked, rsp_valid, "accepted word did not reach the output")

   // A length is only reported together with a found host.
   `XSTE_ASSERT_IMPL(a_length_only_found, clock, reset, rsp_valid && (rsp_word.status != xste_pkg::STATUS_FOUND), rsp_word.host_length == 8'd0, "host length without found status")

endmodule

bind xmpp_stream_to_extractor_core xste_checker u_checker (.*);
